// ===== rtl/core/jbps_pkg.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// jbps_pkg
// Shared types and constants for the JPEG bit packer with byte stuffing.
// -----------------------------------------------------------------------------
package jbps_pkg;

	// Request codes
	localparam logic [1:0] REQ_WRITE  = 2'd0;
	localparam logic [1:0] REQ_MARKER = 2'd1;
	localparam logic [1:0] REQ_FLUSH  = 2'd2;

	// Field widths
	localparam int CODE_W   = 32;
	localparam int COUNT_W  = 6;
	localparam int BYTE_W   = 8;

	// Largest code length taken; longer counts saturate to it
	localparam int MAX_CODE_BITS = 32;
	localparam int EFF_MAX_BITS  = (MAX_CODE_BITS < CODE_W) ? MAX_CODE_BITS : CODE_W;

	// Bit buffer: one pending byte plus one full code
	localparam int BUF_W = CODE_W + BYTE_W;
	// Fill level of the buffer, 0..BUF_W
	localparam int TOT_W = $clog2(BUF_W + 1);

	// Default depth of the byte queue between front and back
	localparam int QUEUE_DEPTH_DEF = 4;

	localparam logic [BYTE_W-1:0] BYTE_FF = 8'hff;

	// One byte handed from front to back
	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              stuff;  // follow a 0xFF with a stuffed zero
		logic              last;   // final byte of its transaction
	} q_entry_t;

endpackage

// ===== rtl/core/jpeg_bit_packer_stuffing_core.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// jpeg_bit_packer_stuffing_core
// Packs variable-length codes MSB first into a JPEG entropy byte stream,
// stuffs a zero after each 0xFF and passes marker bytes through raw.
//
//   Channel  Handshake              Payload
//   -------  ---------------------  ----------------------------------
//   in       in_valid / in_stall    req_type, code_value, bit_count
//   out      out_valid / out_stall  out_byte, last
//
// A write within the pending byte leaves the input free; one completing
// bytes stalls it while the front queues them, one byte a cycle while the
// queue has room. A flush or marker queues any partial byte, a marker then its
// own byte. The back sends one byte a cycle unless stalled, stuffed zeros too.
// Reset clears the pending bits, the byte queue and the output register.
// A stalled output fills the queue, which then stalls the input.
// -----------------------------------------------------------------------------
module jpeg_bit_packer_stuffing_core #(
	parameter int QUEUE_DEPTH = jbps_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    req_type,
	input  logic [jbps_pkg::CODE_W-1:0]   code_value,
	input  logic [jbps_pkg::COUNT_W-1:0]  bit_count,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [jbps_pkg::BYTE_W-1:0]   out_byte,
	output logic                          last
);
	import jbps_pkg::*;

	logic      push;
	q_entry_t  push_entry;
	logic      q_full;
	logic      pop;
	q_entry_t  pop_entry;
	logic      q_empty;

	// Request intake and bit merging
	jbps_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.req_type   (req_type),
		.code_value (code_value),
		.bit_count  (bit_count),
		.push       (push),
		.push_entry (push_entry),
		.q_full     (q_full)
	);

	// Byte queue
	jbps_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (pop),
		.pop_entry  (pop_entry),
		.empty      (q_empty)
	);

	// Stuffing and output
	jbps_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_entry   (pop_entry),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.last      (last)
	);

endmodule

// ===== rtl/core/jbps_front.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// jbps_front
// Accepts requests, merges code bits into the bit buffer and queues each
// completed byte, plus flushed and marker bytes.
// -----------------------------------------------------------------------------
module jbps_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    req_type,
	input  logic [jbps_pkg::CODE_W-1:0]   code_value,
	input  logic [jbps_pkg::COUNT_W-1:0]  bit_count,
	output logic                          push,
	output jbps_pkg::q_entry_t            push_entry,
	input  logic                          q_full
);
	import jbps_pkg::*;

	localparam logic [COUNT_W-1:0] EFF_BITS  = COUNT_W'(EFF_MAX_BITS);
	localparam logic [COUNT_W-1:0] CODE_BITS = COUNT_W'(CODE_W);
	localparam logic [TOT_W-1:0]   TOT_BYTE  = TOT_W'(BYTE_W);

	logic [BUF_W-1:0]   w_q;        // pending bits, MSB aligned, zero below fill
	logic [TOT_W-1:0]   tot_q;      // number of valid bits in w_q
	logic               drain_q;    // push out the partial byte
	logic               mk_q;       // marker byte still to queue
	logic [BYTE_W-1:0]  mk_byte_q;

	logic                busy;
	logic                accept;
	logic                emit_data;
	logic                done;
	logic [TOT_W-1:0]    nt;
	logic [COUNT_W-1:0]  n_sat;
	logic [BUF_W-1:0]    aligned;
	logic [BUF_W-1:0]    ins;

	// Hold off new requests while bytes remain to be queued
	assign busy      = (tot_q > TOT_BYTE) || drain_q || mk_q;
	assign in_stall  = busy;
	assign accept    = in_valid && !busy;

	// Saturate and align the code bits under the pending fill
	assign n_sat   = (bit_count > EFF_BITS) ? EFF_BITS : bit_count;
	assign aligned = {code_value, {BYTE_W{1'b0}}} << (CODE_BITS - n_sat);
	assign ins     = aligned >> tot_q;

	// Byte emission bookkeeping
	assign emit_data = (tot_q > TOT_BYTE) || drain_q;
	assign nt        = (tot_q > TOT_BYTE) ? (tot_q - TOT_BYTE) : '0;
	assign done      = drain_q ? (nt == '0) : (nt <= TOT_BYTE);
	assign push      = !q_full && (emit_data || mk_q);

	always_comb begin
		if (emit_data) begin
			push_entry.data  = w_q[BUF_W-1 -: BYTE_W];
			push_entry.stuff = 1'b1;
			push_entry.last  = done && !mk_q;
		end else begin
			push_entry.data  = mk_byte_q;
			push_entry.stuff = 1'b0;
			push_entry.last  = 1'b1;
		end
	end

	// Advance the buffer on each push, load it on each accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q       <= '0;
			tot_q     <= '0;
			drain_q   <= 1'b0;
			mk_q      <= 1'b0;
			mk_byte_q <= '0;
		end else if (push) begin
			if (emit_data) begin
				w_q   <= {w_q[BUF_W-BYTE_W-1:0], {BYTE_W{1'b0}}};
				tot_q <= nt;
				if (done) begin
					drain_q <= 1'b0;
				end
			end else begin
				mk_q <= 1'b0;
			end
		end else if (accept) begin
			case (req_type)
				REQ_WRITE: begin
					if (n_sat != '0) begin
						w_q   <= w_q | ins;
						tot_q <= tot_q + TOT_W'(n_sat);
					end
				end
				REQ_MARKER: begin
					drain_q   <= (tot_q != '0);
					mk_q      <= 1'b1;
					mk_byte_q <= code_value[BYTE_W-1:0];
				end
				REQ_FLUSH: begin
					drain_q <= (tot_q != '0);
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// ===== rtl/core/jbps_queue.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// jbps_queue
// Small register FIFO of byte entries between front and back.
// -----------------------------------------------------------------------------
module jbps_queue #(
	parameter int DEPTH = jbps_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  jbps_pkg::q_entry_t  push_entry,
	output logic                full,
	input  logic                pop,
	output jbps_pkg::q_entry_t  pop_entry,
	output logic                empty
);
	import jbps_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	q_entry_t          mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  cnt_q;

	logic do_push;
	logic do_pop;

	assign full      = (cnt_q == CNT_FULL);
	assign empty     = (cnt_q == '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && !empty;
	assign pop_entry = mem_q[rd_ptr_q];

	// Store entries
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/core/jbps_back.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// jbps_back
// Drains queued bytes to the output register, inserting a zero after each
// stuffable 0xFF and placing the last flag on the final byte.
// -----------------------------------------------------------------------------
module jbps_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_empty,
	input  jbps_pkg::q_entry_t            q_entry,
	output logic                          pop,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [jbps_pkg::BYTE_W-1:0]   out_byte,
	output logic                          last
);
	import jbps_pkg::*;

	logic               out_valid_q;
	logic [BYTE_W-1:0]  out_byte_q;
	logic               last_q;
	logic               zero_q;       // stuffed zero still to send
	logic               zero_last_q;

	logic load;
	logic needs_stuff;

	assign out_valid   = out_valid_q;
	assign out_byte    = out_byte_q;
	assign last        = last_q;

	assign load        = !out_valid_q || !out_stall;
	assign pop         = load && !zero_q && !q_empty;
	assign needs_stuff = q_entry.stuff && (q_entry.data == BYTE_FF);

	// Refill the output register from the stuffed zero or the queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_byte_q  <= '0;
			last_q      <= 1'b0;
			zero_q      <= 1'b0;
			zero_last_q <= 1'b0;
		end else if (load) begin
			if (zero_q) begin
				out_valid_q <= 1'b1;
				out_byte_q  <= '0;
				last_q      <= zero_last_q;
				zero_q      <= 1'b0;
			end else if (!q_empty) begin
				out_valid_q <= 1'b1;
				out_byte_q  <= q_entry.data;
				last_q      <= q_entry.last && !needs_stuff;
				zero_q      <= needs_stuff;
				zero_last_q <= q_entry.last;
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== bench/tb_jpeg_bit_packer_stuffing_core.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb_jpeg_bit_packer_stuffing_core
// Self-checking bench for the JPEG bit packer. Directed requests cover
// exact fills, empty flushes, stuffed 0xFF bytes, raw markers, saturated and
// zero bit counts and the unused request code. Random requests follow, with
// idle cycles and output stalls. A scoreboard packs every accepted request
// itself and compares each output byte and its last flag in stream order.
// -----------------------------------------------------------------------------
module tb_jpeg_bit_packer_stuffing_core;

	import jbps_pkg::*;

	// Request code that the block ignores
	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam int MAX_REPORTS = 10;
	localparam int RANDOM_REQUESTS = 140;
	localparam int DRAIN_CYCLES = 16;

	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              last;
	} stream_byte_t;

	// Packs accepted requests into the expected byte stream and checks the
	// bytes that leave the block against it
	class stuffing_scoreboard;
		stream_byte_t      expected_bytes[$];
		stream_byte_t      burst[$];
		logic [BYTE_W-1:0] pend_bits = '0;
		int                pend_fill = 0;
		int                mismatches = 0;
		int                bytes_checked = 0;
		int                stuffed_zeros = 0;
		int                req_seen[4] = '{0, 0, 0, 0};

		function logic [63:0] ones(int n);
			return (64'd1 << n) - 64'd1;
		endfunction

		// Queue one byte, plus a zero after 0xFF when stuffing applies
		function void emit(logic [BYTE_W-1:0] b, bit stuff);
			burst.push_back('{data: b, last: 1'b0});
			if (stuff && b == BYTE_FF) begin
				burst.push_back('{data: 8'h00, last: 1'b0});
				stuffed_zeros++;
			end
		endfunction

		function void flush_pending();
			if (pend_fill != 0)
				emit(pend_bits, 1'b1);
			pend_bits = '0;
			pend_fill = 0;
		endfunction

		// Shift the low bits of a code into the pending byte, MSB first
		function void pack_code(logic [CODE_W-1:0] val, logic [COUNT_W-1:0] cnt);
			int          n;
			int          take;
			logic [63:0] v;
			logic [63:0] chunk;
			logic [63:0] shifted;
			n = int'(cnt);
			if (n == 0)
				return;
			if (n > EFF_MAX_BITS)
				n = EFF_MAX_BITS;
			v = {32'b0, val} & ones(n);
			while (n + pend_fill > 8) begin
				take = 8 - pend_fill;
				chunk = (v >> (n - take)) & ones(take);
				emit(pend_bits | chunk[7:0], 1'b1);
				n -= take;
				v &= ones(n);
				pend_bits = '0;
				pend_fill = 0;
			end
			if (n > 0) begin
				shifted = v << (8 - pend_fill - n);
				pend_bits = pend_bits | shifted[7:0];
				pend_fill += n;
			end
		endfunction

		// Work out the bytes that one accepted request causes
		function void note_request(logic [1:0] req, logic [CODE_W-1:0] val,
			logic [COUNT_W-1:0] cnt);
			stream_byte_t tail;
			burst.delete();
			req_seen[req]++;
			case (req)
				REQ_WRITE: begin
					pack_code(val, cnt);
				end
				REQ_MARKER: begin
					flush_pending();
					emit(val[7:0], 1'b0);
				end
				REQ_FLUSH: begin
					flush_pending();
				end
				default: begin
				end
			endcase
			if (burst.size() > 0) begin
				tail = burst.pop_back();
				tail.last = 1'b1;
				burst.push_back(tail);
			end
			foreach (burst[i])
				expected_bytes.push_back(burst[i]);
		endfunction

		function void report(string msg);
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("MISMATCH at %0t: %s", $realtime, msg);
		endfunction

		// Compare one output byte with the oldest expectation
		function void check_byte(logic [BYTE_W-1:0] data, logic lst);
			stream_byte_t want;
			bytes_checked++;
			if (expected_bytes.size() == 0) begin
				report($sformatf("byte %02h last %b with nothing expected", data, lst));
				return;
			end
			want = expected_bytes.pop_front();
			if (data !== want.data)
				report($sformatf("byte %0d: out_byte exp %02h got %02h",
					bytes_checked, want.data, data));
			else if (lst !== want.last)
				report($sformatf("byte %0d (%02h): last exp %b got %b",
					bytes_checked, data, want.last, lst));
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [1:0]         req_type = REQ_WRITE;
	logic [CODE_W-1:0]  code_value = '0;
	logic [COUNT_W-1:0] bit_count = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [BYTE_W-1:0]  out_byte;
	logic               last;

	// Clear both idle sources during the calm stretch of the random part
	bit calm = 1'b0;

	stuffing_scoreboard sb = new();

	jpeg_bit_packer_stuffing_core u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.req_type   (req_type),
		.code_value (code_value),
		.bit_count  (bit_count),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_byte   (out_byte),
		.last       (last)
	);

	always #6 clk = ~clk;

	// Stall the output now and then
	always @(posedge clk) begin
		out_stall <= !calm && ($urandom_range(99) < 9);
	end

	// Check every output transaction
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_byte(out_byte, last);
	end

	// Offer one request, with random idle cycles ahead of it, and hold it
	// until the block takes it
	task automatic send_request(logic [1:0] req, logic [CODE_W-1:0] val,
		logic [COUNT_W-1:0] cnt);
		while (!calm && $urandom_range(99) < 9) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		req_type   <= req;
		code_value <= val;
		bit_count  <= cnt;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_request(req, val, cnt);
	endtask

	// Pick a random request; codes are mostly short, 0xFF runs are common
	task automatic send_random(output bit counted);
		int                 pick;
		int                 sel;
		logic [CODE_W-1:0]  val;
		logic [COUNT_W-1:0] cnt;
		pick = $urandom_range(99);
		val = ($urandom_range(99) < 30) ? 32'hffff_ffff : $urandom();
		sel = $urandom_range(99);
		if (sel < 75)
			cnt = COUNT_W'($urandom_range(16, 1));
		else if (sel < 90)
			cnt = COUNT_W'($urandom_range(32, 17));
		else if (sel < 95)
			cnt = COUNT_W'($urandom_range(63, 33));
		else
			cnt = '0;
		counted = 1'b1;
		if (pick < 70) begin
			send_request(REQ_WRITE, val, cnt);
			counted = (cnt != 0);
		end else if (pick < 82) begin
			if ($urandom_range(99) < 30)
				val[7:0] = BYTE_FF;
			send_request(REQ_MARKER, val, cnt);
		end else if (pick < 95) begin
			send_request(REQ_FLUSH, val, cnt);
		end else begin
			send_request(REQ_UNUSED, val, COUNT_W'($urandom()));
			counted = 1'b0;
		end
	endtask

	initial begin
		int  done;
		bit  counted;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed requests
		send_request(REQ_WRITE, 32'h0000_0001, 6'd1);
		send_request(REQ_WRITE, 32'hffff_ff7f, 6'd7);   // fill exactly to 0xFF
		send_request(REQ_WRITE, 32'hffff_ffff, 6'd0);   // zero count
		send_request(REQ_UNUSED, 32'hffff_ffff, 6'd63);
		send_request(REQ_FLUSH, 32'h0000_0000, 6'd0);   // flushed 0xFF is stuffed
		send_request(REQ_FLUSH, 32'hffff_ffff, 6'd63);  // nothing pending
		send_request(REQ_MARKER, 32'h0000_00d9, 6'd0);  // marker, nothing pending
		send_request(REQ_WRITE, 32'hffff_ffff, 6'd32);
		send_request(REQ_WRITE, 32'h0000_0000, 6'd1);   // push out a full byte
		send_request(REQ_WRITE, 32'ha5a5_a5a5, 6'd63);  // saturated count
		send_request(REQ_WRITE, 32'h5a5a_5a5a, 6'd33);
		send_request(REQ_MARKER, 32'h1234_56ff, 6'd5);  // raw 0xFF after flush
		send_request(REQ_WRITE, 32'h1234_5678, 6'd31);
		send_request(REQ_WRITE, 32'h8000_0001, 6'd42);
		send_request(REQ_WRITE, 32'h0000_0000, 6'd32);
		send_request(REQ_FLUSH, 32'h0000_0000, 6'd0);
		send_request(REQ_WRITE, 32'hdead_beef, 6'd32);
		send_request(REQ_MARKER, 32'hffff_ff00, 6'd63);
		send_request(REQ_WRITE, 32'h0000_ffff, 6'd16);
		send_request(REQ_WRITE, 32'h0000_00ff, 6'd8);
		send_request(REQ_WRITE, 32'h0000_0003, 6'd3);
		send_request(REQ_FLUSH, 32'h0000_0000, 6'd0);

		// Random requests, with a calm stretch in the middle
		done = 0;
		while (done < RANDOM_REQUESTS) begin
			calm = (done >= 60 && done < 110);
			send_random(counted);
			if (counted)
				done++;
		end
		calm = 1'b0;
		send_request(REQ_FLUSH, 32'h0000_0000, 6'd0);
		in_valid <= 1'b0;

		// Drain, then watch for stray bytes
		while (sb.expected_bytes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Requests: %0d writes, %0d markers, %0d flushes, %0d unused codes",
			sb.req_seen[REQ_WRITE], sb.req_seen[REQ_MARKER],
			sb.req_seen[REQ_FLUSH], sb.req_seen[REQ_UNUSED]);
		$display("Bytes checked: %0d (%0d stuffed zeros), mismatches: %0d",
			sb.bytes_checked, sb.stuffed_zeros, sb.mismatches);
		if (sb.mismatches == 0 && sb.expected_bytes.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	// Stop a hung run
	initial begin
		#2_000_000;
		$display("Timeout with %0d bytes still expected", sb.expected_bytes.size());
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ===== jpeg_bit_packer_stuffing_core.f =====
rtl/core/jbps_pkg.sv
rtl/core/jbps_front.sv
rtl/core/jbps_queue.sv
rtl/core/jbps_back.sv
rtl/core/jpeg_bit_packer_stuffing_core.sv
bench/tb_jpeg_bit_packer_stuffing_core.sv
